// ===== rtl/core/ffba_pkg.sv =====
package ffba_pkg;

    // table and heap geometry
    localparam int MAX_BLOCKS = 64;
    localparam int HEAP_BYTES = 65536;

    localparam int IDX_W  = $clog2(MAX_BLOCKS);
    localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
    localparam int OFF_W  = $clog2(HEAP_BYTES + 1);
    localparam int SIZE_W = 16;
    localparam int HDR_W  = 8;
    localparam int ADDR_W = 16;
    // wide enough for offset plus header plus request without wrapping
    localparam int SUM_W  = ((OFF_W > SIZE_W) ? OFF_W : SIZE_W + 1) + 1;

    // configuration port
    localparam int PADDR_W = 2;
    localparam int PDATA_W = 32;
    localparam logic [PADDR_W-1:0] REG_HEADER = PADDR_W'(0);
    localparam logic [HDR_W-1:0] HEADER_RESET = HDR_W'(25);

    // result status codes
    localparam logic [2:0] ST_REUSED  = 3'd0;
    localparam logic [2:0] ST_SPLIT   = 3'd1;
    localparam logic [2:0] ST_GROWN   = 3'd2;
    localparam logic [2:0] ST_ZERO    = 3'd3;
    localparam logic [2:0] ST_NOROOM  = 3'd4;
    localparam logic [2:0] ST_FREED   = 3'd5;
    localparam logic [2:0] ST_IGNORED = 3'd6;

    // input actions
    localparam logic ACT_ALLOC   = 1'b0;
    localparam logic ACT_RELEASE = 1'b1;

    // one block table entry
    typedef struct packed {
        logic [OFF_W-1:0]  offset;
        logic [SIZE_W-1:0] size;
        logic              is_free;
    } entry_t;

    // sequencer states
    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SCAN   = 5'b00010,
        S_SHIFT  = 5'b00100,
        S_REMAIN = 5'b01000,
        S_RESP   = 5'b10000
    } state_t;

endpackage

// ===== rtl/core/first_fit_block_allocator_unit.sv =====
// First-fit heap allocator with block splitting over an address-ordered table.
// Input channel: item_valid/item_stall with action, request_size,
// release_address and release_is_null; an item is taken when item_valid is
// high and item_stall is low. item_stall stays high from acceptance until the
// result has been moved into the output register.
// Output channel: result_valid/result_stall with payload_address and status.
// The output register lets the next item be taken while a result waits.
// An allocate or release reads the table one entry a cycle through the
// single memory read port, over at most the n blocks in use, and stops
// at the first hit. A split also moves every entry above the chosen one
// up by one slot, one entry a cycle through the same port, and then
// writes the remainder entry. Zero-size allocates and null releases skip
// the table. The next item is taken in the cycle after the result is
// loaded, so the block takes no new item before it is through with the
// last one.
// A stalled receiver holds the result; the block then finishes its current
// item and waits before taking another.
// Reset empties the table and the heap and sets header_size to 25; no
// clearing pass runs. header_size is written through the APB port at
// address 0 and must only change while the block is idle.
module first_fit_block_allocator_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ffba_pkg::PADDR_W-1:0]   paddr,
    input  logic [ffba_pkg::PDATA_W-1:0]   pwdata,
    output logic [ffba_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready,
    // input items
    input  logic                           item_valid,
    output logic                           item_stall,
    input  logic                           action,
    input  logic [ffba_pkg::SIZE_W-1:0]    request_size,
    input  logic [ffba_pkg::ADDR_W-1:0]    release_address,
    input  logic                           release_is_null,
    // result items
    output logic                           result_valid,
    input  logic                           result_stall,
    output logic [ffba_pkg::ADDR_W-1:0]    payload_address,
    output logic [2:0]                     status
);
    import ffba_pkg::*;

    // block table memory
    entry_t mem [MAX_BLOCKS];
    entry_t rd_data_reg;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;

    // control and working registers
    state_t            state_reg, state_next;
    logic [HDR_W-1:0]  hdr_reg, hdr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [OFF_W-1:0]  heap_top_reg, heap_top_next;
    logic              act_reg, act_next;
    logic [SIZE_W-1:0] req_reg, req_next;
    logic [ADDR_W-1:0] rel_addr_reg, rel_addr_next;
    logic [CNT_W-1:0]  scan_idx_reg, scan_idx_next;
    logic              pend_reg, pend_next;
    logic [IDX_W-1:0]  cur_reg, cur_next;
    logic [IDX_W-1:0]  hit_idx_reg, hit_idx_next;
    logic [CNT_W-1:0]  sh_idx_reg, sh_idx_next;
    logic [OFF_W-1:0]  rem_off_reg, rem_off_next;
    logic [SIZE_W-1:0] rem_size_reg, rem_size_next;
    logic [ADDR_W-1:0] res_addr_reg, res_addr_next;
    logic [2:0]        res_status_reg, res_status_next;
    logic              out_valid_reg, out_valid_next;
    logic [ADDR_W-1:0] out_addr_reg, out_addr_next;
    logic [2:0]        out_status_reg, out_status_next;

    // shared arithmetic on the entry under test and the heap top
    logic [SUM_W-1:0]  ent_pay;
    logic [SUM_W-1:0]  need;
    logic [SUM_W-1:0]  split_off;
    logic [SUM_W-1:0]  grow_top;
    logic [SUM_W-1:0]  grow_pay;
    logic              fit_hit;
    logic              match_hit;
    logic              can_split;
    logic              shift_issue;

    assign pready       = 1'b1;
    assign item_stall   = (state_reg != S_IDLE);
    assign result_valid = out_valid_reg;
    assign payload_address = out_addr_reg;
    assign status       = out_status_reg;

    // register read-back
    always_comb
    begin
        prdata = '0;
        if (paddr == REG_HEADER)
        begin
            prdata = PDATA_W'(hdr_reg);
        end
    end

    // datapath terms
    always_comb
    begin
        ent_pay   = SUM_W'(rd_data_reg.offset) + SUM_W'(hdr_reg);
        need      = SUM_W'(req_reg) + SUM_W'(hdr_reg);
        split_off = SUM_W'(rd_data_reg.offset) + need;
        grow_top  = SUM_W'(heap_top_reg) + need;
        grow_pay  = SUM_W'(heap_top_reg) + SUM_W'(hdr_reg);
        fit_hit   = pend_reg && rd_data_reg.is_free && (rd_data_reg.size >= req_reg);
        match_hit = pend_reg && (ent_pay == SUM_W'(rel_addr_reg));
        can_split = (SUM_W'(rd_data_reg.size) >= need) &&
                    (count_reg < CNT_W'(MAX_BLOCKS));
        shift_issue = (sh_idx_reg > CNT_W'(hit_idx_reg));
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        hdr_next        = hdr_reg;
        count_next      = count_reg;
        heap_top_next   = heap_top_reg;
        act_next        = act_reg;
        req_next        = req_reg;
        rel_addr_next   = rel_addr_reg;
        scan_idx_next   = scan_idx_reg;
        pend_next       = pend_reg;
        cur_next        = cur_reg;
        hit_idx_next    = hit_idx_reg;
        sh_idx_next     = sh_idx_reg;
        rem_off_next    = rem_off_reg;
        rem_size_next   = rem_size_reg;
        res_addr_next   = res_addr_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg;
        out_addr_next   = out_addr_reg;
        out_status_next = out_status_reg;
        rd_addr         = scan_idx_reg[IDX_W-1:0];
        wr_en           = 1'b0;
        wr_addr         = cur_reg;
        wr_data         = rd_data_reg;

        // configuration write
        if (psel && penable && pwrite && pready && (paddr == REG_HEADER))
        begin
            hdr_next = pwdata[HDR_W-1:0];
        end

        // result taken downstream
        if (out_valid_reg && !result_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    act_next      = action;
                    req_next      = request_size;
                    rel_addr_next = release_address;
                    scan_idx_next = '0;
                    pend_next     = 1'b0;
                    res_addr_next = '0;
                    if ((action == ACT_ALLOC) && (request_size == '0))
                    begin
                        res_status_next = ST_ZERO;
                        state_next      = S_RESP;
                    end
                    else if ((action == ACT_RELEASE) && release_is_null)
                    begin
                        res_status_next = ST_IGNORED;
                        state_next      = S_RESP;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                if ((act_reg == ACT_ALLOC) && fit_hit)
                begin
                    // first fitting free block
                    res_addr_next  = ent_pay[ADDR_W-1:0];
                    wr_en          = 1'b1;
                    wr_addr        = cur_reg;
                    wr_data        = rd_data_reg;
                    wr_data.is_free = 1'b0;
                    pend_next      = 1'b0;
                    if (can_split)
                    begin
                        wr_data.size    = req_reg;
                        rem_off_next    = split_off[OFF_W-1:0];
                        rem_size_next   = rd_data_reg.size - need[SIZE_W-1:0];
                        hit_idx_next    = cur_reg;
                        sh_idx_next     = count_reg - CNT_W'(1);
                        res_status_next = ST_SPLIT;
                        state_next      = S_SHIFT;
                    end
                    else
                    begin
                        res_status_next = ST_REUSED;
                        state_next      = S_RESP;
                    end
                end
                else if ((act_reg == ACT_RELEASE) && match_hit)
                begin
                    // matching payload address
                    wr_en           = 1'b1;
                    wr_addr         = cur_reg;
                    wr_data         = rd_data_reg;
                    wr_data.is_free = 1'b1;
                    pend_next       = 1'b0;
                    res_status_next = ST_FREED;
                    state_next      = S_RESP;
                end
                else if (scan_idx_reg < count_reg)
                begin
                    // issue the next table read
                    rd_addr       = scan_idx_reg[IDX_W-1:0];
                    cur_next      = scan_idx_reg[IDX_W-1:0];
                    pend_next     = 1'b1;
                    scan_idx_next = scan_idx_reg + CNT_W'(1);
                end
                else if (pend_reg)
                begin
                    // last entry checked without a hit
                    pend_next = 1'b0;
                end
                else if (act_reg == ACT_RELEASE)
                begin
                    res_status_next = ST_IGNORED;
                    state_next      = S_RESP;
                end
                else if ((count_reg == CNT_W'(MAX_BLOCKS)) ||
                         (grow_top > SUM_W'(HEAP_BYTES)))
                begin
                    res_status_next = ST_NOROOM;
                    state_next      = S_RESP;
                end
                else
                begin
                    // append a block at the heap top
                    wr_en           = 1'b1;
                    wr_addr         = count_reg[IDX_W-1:0];
                    wr_data.offset  = heap_top_reg;
                    wr_data.size    = req_reg;
                    wr_data.is_free = 1'b0;
                    count_next      = count_reg + CNT_W'(1);
                    heap_top_next   = grow_top[OFF_W-1:0];
                    res_addr_next   = grow_pay[ADDR_W-1:0];
                    res_status_next = ST_GROWN;
                    state_next      = S_RESP;
                end
            end

            S_SHIFT:
            begin
                // move entries above the split block up one slot, top first
                if (shift_issue)
                begin
                    rd_addr     = sh_idx_reg[IDX_W-1:0];
                    cur_next    = sh_idx_reg[IDX_W-1:0];
                    pend_next   = 1'b1;
                    sh_idx_next = sh_idx_reg - CNT_W'(1);
                end
                else
                begin
                    pend_next = 1'b0;
                end
                if (pend_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = cur_reg + IDX_W'(1);
                    wr_data = rd_data_reg;
                end
                if (!shift_issue && !pend_reg)
                begin
                    state_next = S_REMAIN;
                end
            end

            S_REMAIN:
            begin
                // remainder becomes a free block right after the split one
                wr_en           = 1'b1;
                wr_addr         = hit_idx_reg + IDX_W'(1);
                wr_data.offset  = rem_off_reg;
                wr_data.size    = rem_size_reg;
                wr_data.is_free = 1'b1;
                count_next      = count_reg + CNT_W'(1);
                state_next      = S_RESP;
            end

            S_RESP:
            begin
                if (!out_valid_reg || !result_stall)
                begin
                    out_valid_next  = 1'b1;
                    out_addr_next   = res_addr_reg;
                    out_status_next = res_status_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control and working registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            hdr_reg        <= HEADER_RESET;
            count_reg      <= '0;
            heap_top_reg   <= '0;
            act_reg        <= 1'b0;
            req_reg        <= '0;
            rel_addr_reg   <= '0;
            scan_idx_reg   <= '0;
            pend_reg       <= 1'b0;
            cur_reg        <= '0;
            hit_idx_reg    <= '0;
            sh_idx_reg     <= '0;
            rem_off_reg    <= '0;
            rem_size_reg   <= '0;
            res_addr_reg   <= '0;
            res_status_reg <= '0;
            out_valid_reg  <= 1'b0;
            out_addr_reg   <= '0;
            out_status_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            hdr_reg        <= hdr_next;
            count_reg      <= count_next;
            heap_top_reg   <= heap_top_next;
            act_reg        <= act_next;
            req_reg        <= req_next;
            rel_addr_reg   <= rel_addr_next;
            scan_idx_reg   <= scan_idx_next;
            pend_reg       <= pend_next;
            cur_reg        <= cur_next;
            hit_idx_reg    <= hit_idx_next;
            sh_idx_reg     <= sh_idx_next;
            rem_off_reg    <= rem_off_next;
            rem_size_reg   <= rem_size_next;
            res_addr_reg   <= res_addr_next;
            res_status_reg <= res_status_next;
            out_valid_reg  <= out_valid_next;
            out_addr_reg   <= out_addr_next;
            out_status_reg <= out_status_next;
        end
    end

    // table memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

endmodule
